// ===== hw/rtl/trial_division_prime_test_top_macros.svh =====
// assertion macros for the trial division prime test
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH

// same-cycle implication, reset masked
`define TDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define TDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tdp_pkg.sv =====
// shared types and constants for the trial division prime test
package tdp_pkg;

  localparam int unsigned NumWidthDefault = 24;
  localparam int unsigned FirstDivisor    = 3;
  localparam int unsigned DivisorStep     = 2;

  typedef struct packed {
    logic load;
    logic start_div;
    logic div_step;
    logic next_div;
  } tdp_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_two;
    logic n_even;
    logic sq_gt_n;
    logic div_last;
    logic rem_zero;
  } tdp_stat_t;

endpackage

// ===== hw/rtl/tdp_if.sv =====
// handshake channel interfaces for candidate and result items
interface tdp_cand_if #(
  parameter int unsigned NUM_WIDTH = 24
);
  logic                 valid;
  logic                 ready;
  logic [NUM_WIDTH-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_result_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

// ===== hw/rtl/tdp_datapath.sv =====
// datapath: candidate, odd divisor, its square and a bit-serial remainder unit
`include "trial_division_prime_test_top_macros.svh"

module tdp_datapath #(
  parameter int unsigned NUM_WIDTH = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tdp_pkg::tdp_cmd_t    cmd_i,
  input  logic [NUM_WIDTH-1:0] candidate_i,
  output tdp_pkg::tdp_stat_t   stat_o
);
  import tdp_pkg::*;

  localparam int unsigned DW = NUM_WIDTH / 2 + 2;
  localparam int unsigned SW = 2 * DW;
  localparam int unsigned IW = $clog2(NUM_WIDTH);

  logic [NUM_WIDTH-1:0] n_q, n_d;
  logic [DW-1:0]        d_q, d_d;
  logic [SW-1:0]        sq_q, sq_d;
  logic [DW-1:0]        r_q, r_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [DW:0]          r_shift;
  logic [DW:0]          r_sub;

  assign r_shift = {r_q, n_q[idx_q]};
  assign r_sub   = r_shift - {1'b0, d_q};

  always_comb begin
    n_d   = n_q;
    d_d   = d_q;
    sq_d  = sq_q;
    r_d   = r_q;
    idx_d = idx_q;
    if (cmd_i.load) begin
      n_d  = candidate_i;
      d_d  = DW'(FirstDivisor);
      sq_d = SW'(FirstDivisor * FirstDivisor);
      r_d  = '0;
    end
    if (cmd_i.start_div) begin
      r_d   = '0;
      idx_d = IW'(NUM_WIDTH - 1);
    end
    if (cmd_i.div_step) begin
      if (r_shift >= {1'b0, d_q}) begin
        r_d = r_sub[DW-1:0];
      end else begin
        r_d = r_shift[DW-1:0];
      end
      idx_d = idx_q - IW'(1);
    end
    if (cmd_i.next_div) begin
      // (d + 2)^2 = d^2 + 4d + 4
      d_d  = d_q + DW'(DivisorStep);
      sq_d = sq_q + {{(SW-DW-2){1'b0}}, d_q, 2'b00} + SW'(DivisorStep * DivisorStep);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      d_q   <= DW'(FirstDivisor);
      sq_q  <= SW'(FirstDivisor * FirstDivisor);
      r_q   <= '0;
      idx_q <= '0;
    end else begin
      n_q   <= n_d;
      d_q   <= d_d;
      sq_q  <= sq_d;
      r_q   <= r_d;
      idx_q <= idx_d;
    end
  end

  assign stat_o.n_lt2    = (n_q[NUM_WIDTH-1:1] == '0);
  assign stat_o.n_two    = (n_q == NUM_WIDTH'(2));
  assign stat_o.n_even   = ~n_q[0];
  assign stat_o.sq_gt_n  = (sq_q > SW'(n_q));
  assign stat_o.div_last = (idx_q == '0);
  assign stat_o.rem_zero = (r_q == '0);

  `TDP_ASSERT_NOW(a_rem_below_div, 1'b1, r_q < d_q, "remainder not below divisor")
  `TDP_ASSERT_NOW(a_div_odd, 1'b1, d_q[0], "divisor became even")
  `TDP_ASSERT_NOW(a_sq_track, 1'b1, sq_q == SW'(d_q) * SW'(d_q), "square out of step")

endmodule

// ===== hw/rtl/tdp_ctrl.sv =====
// controller: sequences the checks, the remainder passes and the result register
`include "trial_division_prime_test_top_macros.svh"

module tdp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               is_prime_o,
  output tdp_pkg::tdp_cmd_t  cmd_o,
  input  tdp_pkg::tdp_stat_t stat_i
);
  import tdp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_TEST,
    S_DONE
  } state_e;

  state_e st_q, st_d;
  logic   verdict_q, verdict_d;
  logic   out_valid_q, out_valid_d;
  logic   is_prime_q, is_prime_d;
  logic   out_free;

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;
  assign out_free    = ~out_valid_q | out_ready_i;

  always_comb begin
    st_d        = st_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    is_prime_d  = is_prime_q;
    cmd_o       = '0;
    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          st_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.n_lt2 || (stat_i.n_even && !stat_i.n_two)) begin
          verdict_d = 1'b0;
          st_d      = S_DONE;
        end else if (stat_i.n_two || stat_i.sq_gt_n) begin
          verdict_d = 1'b1;
          st_d      = S_DONE;
        end else begin
          cmd_o.start_div = 1'b1;
          st_d            = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          st_d = S_TEST;
        end
      end
      S_TEST: begin
        if (stat_i.rem_zero) begin
          verdict_d = 1'b0;
          st_d      = S_DONE;
        end else begin
          cmd_o.next_div = 1'b1;
          st_d           = S_CHECK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          is_prime_d  = verdict_q;
          st_d        = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      verdict_q   <= 1'b0;
      out_valid_q <= 1'b0;
      is_prime_q  <= 1'b0;
    end else begin
      st_q        <= st_d;
      verdict_q   <= verdict_d;
      out_valid_q <= out_valid_d;
      is_prime_q  <= is_prime_d;
    end
  end

  `TDP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
                   "item accepted while busy")
  `TDP_ASSERT_NEXT(a_done_posts, st_q == S_DONE && out_free, out_valid_q,
                   "finished item not posted")
  `TDP_ASSERT_NEXT(a_div_to_test, st_q == S_DIV && stat_i.div_last, st_q == S_TEST,
                   "remainder pass overran")

endmodule

// ===== hw/rtl/trial_division_prime_test_top.sv =====
// top level of the trial division prime test
// Tests one unsigned candidate per item and returns one is_prime flag. Zero and
// one give 0, two gives 1, other even values give 0; such flags are decided in
// S_CHECK and pass through S_DONE into the output register. An odd candidate n
// is divided by 3, 5, 7, ... while d*d <= n; each odd divisor takes one pass of
// the bit-serial remainder unit, which takes one bit of n per cycle, so a prime
// near 2^NUM_WIDTH needs about 2^(NUM_WIDTH/2) / 2 such passes.
// One item is in work at a time; a new item is taken while the previous result
// still waits in the output register.
module trial_division_prime_test_top #(
  parameter int unsigned NUM_WIDTH = tdp_pkg::NumWidthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tdp_cand_if.sink     cand_i,
  tdp_result_if.source result_o
);
  import tdp_pkg::*;

  tdp_cmd_t  cmd;
  tdp_stat_t stat;

  tdp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cand_i.valid),
    .in_ready_o  (cand_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .is_prime_o  (result_o.is_prime),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  tdp_datapath #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .candidate_i (cand_i.candidate),
    .stat_o      (stat)
  );

endmodule

// ===== tb/trial_division_prime_test_top_tb.sv =====
// testbench for the trial division prime test: checks every is_prime flag against its own predictor
module trial_division_prime_test_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumWidth    = tdp_pkg::NumWidthDefault;
  localparam int unsigned WatchLimit  = 250000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 50;
  localparam int unsigned ReportMax   = 10;

  typedef struct {
    logic [NumWidth-1:0] candidate;
    bit                  is_prime;
  } prime_expect_t;

  logic clk_i;
  logic rst_ni;

  tdp_cand_if #(.NUM_WIDTH(NumWidth)) cand_bus ();
  tdp_result_if                       result_bus ();

  trial_division_prime_test_top #(
    .NUM_WIDTH(NumWidth)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cand_i  (cand_bus),
    .result_o(result_bus)
  );

  prime_expect_t pending_flags[$];
  int unsigned   mismatch_count;
  int unsigned   candidates_sent;
  int unsigned   flags_checked;
  int unsigned   primes_seen;
  int unsigned   quiet_cycles;
  int unsigned   hold_left;
  int unsigned   stall_left;
  bit            sender_gaps;
  bit            receiver_stalls;
  bit            hold_off_req;
  bit            receiver_stalled;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic bit prime_flag(logic [NumWidth-1:0] n);
    longint unsigned value;
    longint unsigned divisor;
    value = 64'(n);
    if (value < 2) return 1'b0;
    if (value == 2) return 1'b1;
    if (value[0] == 1'b0) return 1'b0;
    for (divisor = tdp_pkg::FirstDivisor; divisor * divisor <= value;
         divisor += tdp_pkg::DivisorStep) begin
      if (value % divisor == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // mostly no gap or a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_candidate(input logic [NumWidth-1:0] n);
    prime_expect_t entry;
    int unsigned   gap;
    cand_bus.valid     <= 1'b1;
    cand_bus.candidate <= n;
    @(posedge clk_i);
    while (!cand_bus.ready) @(posedge clk_i);
    entry.candidate = n;
    entry.is_prime  = prime_flag(n);
    pending_flags.insert(pending_flags.size(), entry);
    candidates_sent++;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      cand_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic test_directed_values();
    logic [NumWidth-1:0] values[$];
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    values = '{0, 1, 2, 3, 4, 5, 9, 15, 25, 49, 97, 121, 65521, 8388608,
               16777214, 16777215, 16752649, 16777213};
    foreach (values[i]) send_candidate(values[i]);
  endtask

  // odd values favoured, even ones still reached
  task automatic test_random_small();
    logic [NumWidth-1:0] n;
    repeat (25) begin
      n = NumWidth'($urandom_range(0, 4095));
      if ($urandom_range(0, 3) != 0) n[0] = 1'b1;
      send_candidate(n);
    end
  endtask

  task automatic test_random_wide();
    logic [NumWidth-1:0] n;
    repeat (20) begin
      n = NumWidth'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) != 0) n[0] = 1'b1;
      send_candidate(n);
    end
    repeat (3) begin
      n = NumWidth'($urandom());
      send_candidate(n);
    end
  endtask

  task automatic test_back_to_back();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    repeat (12) send_candidate(NumWidth'($urandom_range(0, 1023)));
  endtask

  task automatic test_output_hold();
    sender_gaps  = 1'b0;
    hold_off_req = 1'b1;
    repeat (8) send_candidate(NumWidth'($urandom_range(0, 511)));
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    rst_ni             = 1'b0;
    cand_bus.valid     = 1'b0;
    cand_bus.candidate = '0;
    mismatch_count     = 0;
    candidates_sent    = 0;
    flags_checked      = 0;
    primes_seen        = 0;
    sender_gaps        = 1'b1;
    receiver_stalls    = 1'b1;
    hold_off_req       = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_values();
    test_random_small();
    test_random_wide();
    test_back_to_back();
    test_output_hold();
    test_random_small();
    cand_bus.valid <= 1'b0;

    while (pending_flags.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Summary: %0d candidates tested, %0d flags checked, %0d of them prime",
             candidates_sent, flags_checked, primes_seen);
    $display("Covered edge values, small and wide random values, back to back and output hold");
    if (mismatch_count == 0 && pending_flags.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: random stalls plus one long hold on request
  initial begin
    result_bus.ready = 1'b0;
    hold_left        = 0;
    stall_left       = 0;
    receiver_stalled = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_left    = HoldCycles;
        hold_off_req = 1'b0;
      end
      if (hold_left == 0 && stall_left == 0 && receiver_stalls &&
          $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      receiver_stalled = (hold_left > 0) || (stall_left > 0);
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
      result_bus.ready <= !receiver_stalled;
    end
  end

  always @(posedge clk_i) begin
    prime_expect_t entry;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (pending_flags.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportMax)
          $display("unexpected result item: is_prime %0b", result_bus.is_prime);
      end else begin
        entry = pending_flags.pop_front();
        flags_checked++;
        if (entry.is_prime) primes_seen++;
        if (result_bus.is_prime !== entry.is_prime) begin
          mismatch_count++;
          if (mismatch_count <= ReportMax)
            $display("mismatch for candidate %0d: expected is_prime %0b, got %0b",
                     entry.candidate, entry.is_prime, result_bus.is_prime);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cand_bus.valid && cand_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WatchLimit) begin
        $display("timeout: no item moved for %0d cycles", WatchLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
